// ===== hw/rtl/rme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants for the modular exponentiation block
// Holds the configuration register map and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rme_pkg;

  // configuration register index
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(1);

  // exponentiation sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_MUL,
    ST_SQR
  } rme_state_t;

endpackage : rme_pkg
`default_nettype wire

// ===== hw/rtl/rme_modred.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_modred: bit-serial modular reduction
// Shifts the value in MSB first, one bit per cycle, keeping a remainder below
// the modulus with one compare and subtract per step. W steps per value.
// ----------------------------------------------------------------------------
module rme_modred #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] value,
  input  wire logic [W-1:0] modulus,
  output logic              done,
  output logic [W-1:0]      remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     shift_r, shift_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [W:0] trial;
  logic [W:0] trial_sub;

  always_comb begin
    trial     = {rem_r, shift_r[W-1]};
    trial_sub = trial - {1'b0, modulus};
  end

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = value;
      rem_nxt   = '0;
      cnt_nxt   = CNT_W'(W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[W-2:0], 1'b0};
      rem_nxt   = (trial >= {1'b0, modulus}) ? trial_sub[W-1:0] : trial[W-1:0];
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule : rme_modred
`default_nettype wire

// ===== hw/rtl/rme_modmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rme_modmul: bit-serial shift-and-add modular multiplier
// Consumes the multiplier LSB first. Each cycle adds the multiplicand into
// the accumulator when the bit is set and doubles the multiplicand, both
// modulo m. Stops once the remaining multiplier bits are all zero.
// Operands must be below the modulus.
// ----------------------------------------------------------------------------
module rme_modmul #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] op_a,
  input  wire logic [W-1:0] op_b,
  input  wire logic [W-1:0] modulus,
  output logic              done,
  output logic [W-1:0]      product
);

  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  logic [W:0] sum_acc, sum_acc_sub;
  logic [W:0] dbl, dbl_sub;
  logic [W:0] mod_ext;

  always_comb begin
    mod_ext     = {1'b0, modulus};
    sum_acc     = {1'b0, acc_r} + {1'b0, a_r};
    sum_acc_sub = sum_acc - mod_ext;
    dbl         = {a_r, 1'b0};
    dbl_sub     = dbl - mod_ext;
  end

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = (sum_acc >= mod_ext) ? sum_acc_sub[W-1:0] : sum_acc[W-1:0];
      end
      a_nxt = (dbl >= mod_ext) ? dbl_sub[W-1:0] : dbl[W-1:0];
      b_nxt = {1'b0, b_r[W-1:1]};
      // finished once no set bit remains above the current one
      if (b_r[W-1:1] == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule : rme_modmul
`default_nettype wire

// ===== hw/rtl/rsa_modular_exponentiation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation: raw RSA modular exponentiation core
// Computes base ^ exponent mod modulus with bit-serial reduction and a shared
// bit-serial shift-and-add modular multiplier, right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Usage: load modulus (index 0) and exponent (index 1) through the cfg port
// while busy is low. Pulse start with in_base_value while busy is low; busy
// rises and stays high until the result transfer. The result is presented on
// out_power_result for exactly one cycle with out_valid; there is no
// back-pressure, so the receiver must capture it in that cycle. A new start is
// taken from the cycle the result appears. Sequence: the input reduction,
// then for each exponent bit up to the top set bit one dispatch state, a
// modular multiply where the bit is set and a modular square (the square
// after the top set bit is skipped), then a closing dispatch state before
// the result. Each modular product runs over the bit length L of its second
// operand, the base (L at least 1, at most DATA_WIDTH), as the single shared
// multiplier retires one multiplier bit per cycle. A modulus of 0 acts as 1;
// a zero exponent gives 1 mod modulus.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation
  import rme_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_WIDTH-1:0] cfg_wdata,
  // command
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] in_base_value,
  // result
  output logic                       out_valid,
  output logic [DATA_WIDTH-1:0]      out_power_result
);

  localparam int W = DATA_WIDTH;

  // configuration registers
  logic [W-1:0] modulus_r;
  logic [W-1:0] exponent_r;

  // datapath registers
  rme_state_t   state_r, state_nxt;
  logic [W-1:0] base_r, base_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_result_r, out_result_nxt;

  // effective modulus: zero is treated as one
  logic [W-1:0] mod_eff;

  // reducer and multiplier hookup
  logic         red_start;
  logic         red_done;
  logic [W-1:0] red_rem;
  logic         mm_start;
  logic [W-1:0] mm_a, mm_b;
  logic         mm_done;
  logic [W-1:0] mm_prod;

  assign mod_eff = (modulus_r == '0) ? W'(1) : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(1);
      exponent_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  rme_modred #(.W(W)) u_modred (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (red_start),
    .value     (in_base_value),
    .modulus   (mod_eff),
    .done      (red_done),
    .remainder (red_rem)
  );

  rme_modmul #(.W(W)) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (mod_eff),
    .done    (mm_done),
    .product (mm_prod)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    acc_nxt        = acc_r;
    exp_nxt        = exp_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    red_start      = 1'b0;
    mm_start       = 1'b0;
    mm_a           = base_r;
    mm_b           = base_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          red_start = 1'b1;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          base_nxt  = red_rem;
          // 1 mod m: zero only for a modulus of one
          acc_nxt   = (mod_eff == W'(1)) ? '0 : W'(1);
          exp_nxt   = exponent_r;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (exp_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          state_nxt      = ST_IDLE;
        end else if (exp_r[0]) begin
          mm_start  = 1'b1;
          mm_a      = acc_r;
          mm_b      = base_r;
          state_nxt = ST_MUL;
        end else begin
          mm_start  = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_nxt = mm_prod;
          if (exp_r[W-1:1] == '0) begin
            // top set bit done, the trailing square is not needed
            exp_nxt   = '0;
            state_nxt = ST_NEXT;
          end else begin
            mm_start  = 1'b1;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          base_nxt  = mm_prod;
          exp_nxt   = {1'b0, exp_r[W-1:1]};
          state_nxt = ST_NEXT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r       <= base_nxt;
    acc_r        <= acc_nxt;
    exp_r        <= exp_nxt;
    out_result_r <= out_result_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_result_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a result transfer leaves the sequencer idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer not idle");

  // an accepted command starts the input reduction
  a_start_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_REDUCE))
    else $error("accepted command did not start reduction");

  // the reducer only finishes while the sequencer waits for it
  a_red_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> (state_r == ST_REDUCE))
    else $error("reduction finished outside reduce state");

  // multiplier operands stay reduced below the modulus
  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MUL) || (state_r == ST_SQR)) |->
      ((base_r < mod_eff) && (acc_r < mod_eff)))
    else $error("operand not reduced below modulus");

  // the multiplier finishes only while a product is outstanding
  a_mm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> ((state_r == ST_MUL) || (state_r == ST_SQR)))
    else $error("product finished with none outstanding");

endmodule : rsa_modular_exponentiation
`default_nettype wire
